// ===== design/fsmc_pkg.sv =====
package fsmc_pkg;

  localparam int OUT_CELL_W  = 32;
  localparam int OUT_DEPTH_W = 7;
  localparam int OP_COUNT    = 44;

  typedef enum logic [5:0] {
    OP_LIT, OP_DUP, OP_DUP2, OP_QDUP, OP_OVER, OP_OVER2, OP_PICK, OP_DROP,
    OP_DROP2, OP_NIP, OP_ROLL, OP_ROT, OP_MROT, OP_SWAP, OP_SWAP2, OP_TO_R,
    OP_R_FROM, OP_R_FETCH, OP_DEPTH, OP_DEPTH_SET, OP_RDEPTH, OP_RDEPTH_SET,
    OP_ADD, OP_SUB, OP_MUL, OP_UMUL, OP_ABS, OP_NEGATE, OP_MAX, OP_MIN,
    OP_LSHIFT, OP_RSHIFT, OP_ASHIFT, OP_AND, OP_OR, OP_XOR, OP_INVERT,
    OP_EQ, OP_GT, OP_LT, OP_UGT, OP_ULT, OP_I, OP_J
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD, S_RCAP, S_RRD, S_RRCAP, S_CALC,
    S_XRD, S_XCAP, S_RL_RD, S_RL_WR, S_WR, S_FT, S_FTCAP, S_OUT
  } state_t;

  function automatic logic [2:0] op_dneed(op_t op);
    case (op)
      OP_LIT, OP_R_FROM, OP_R_FETCH, OP_DEPTH, OP_RDEPTH, OP_I, OP_J: op_dneed = 3'd0;
      OP_DUP, OP_QDUP, OP_PICK, OP_DROP, OP_ROLL, OP_TO_R, OP_DEPTH_SET,
      OP_RDEPTH_SET, OP_ABS, OP_NEGATE, OP_INVERT: op_dneed = 3'd1;
      OP_ROT, OP_MROT: op_dneed = 3'd3;
      OP_OVER2, OP_SWAP2: op_dneed = 3'd4;
      default: op_dneed = 3'd2;
    endcase
  endfunction

  function automatic logic [1:0] op_rneed(op_t op);
    case (op)
      OP_R_FROM, OP_R_FETCH, OP_I: op_rneed = 2'd1;
      OP_J: op_rneed = 2'd3;
      default: op_rneed = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] op_dpush(op_t op);
    case (op)
      OP_LIT, OP_DUP, OP_QDUP, OP_OVER, OP_R_FROM, OP_R_FETCH, OP_DEPTH,
      OP_RDEPTH, OP_I, OP_J: op_dpush = 2'd1;
      OP_DUP2, OP_OVER2: op_dpush = 2'd2;
      default: op_dpush = 2'd0;
    endcase
  endfunction

endpackage

// ===== design/forth_stack_machine_core.sv =====
// Forth stack machine core: executes one primitive per request on an internal
// data stack and return stack.
// The input channel carries in_operation and in_literal; a request is taken
// when in_valid is high and in_stall is low. The result channel carries the
// data stack top, both depths and a fault flag, taken when out_valid is high
// and out_stall is low.
// One request is worked at a time. After the request is taken it is decoded,
// the needed data stack entries are read one by one, then the return stack
// entry if the word needs one, the result is computed, and the new entries are
// written one by one before the top is fetched for the result; pick and roll
// add an indexed read, and roll then shifts the entries above it down.
// The data stack memory has a single read port.
// After reset both stacks are swept to zero, one entry a cycle, while in_stall
// stays high.
// While the receiver stalls, the result is held and no new request is taken.
module forth_stack_machine_core #(
  parameter int CELL_BITS    = 32,
  parameter int DATA_DEPTH   = 64,
  parameter int RETURN_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [5:0]                       in_operation,
  input  logic [31:0]                      in_literal,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fsmc_pkg::OUT_CELL_W-1:0]  out_top_value,
  output logic [fsmc_pkg::OUT_DEPTH_W-1:0] out_data_depth,
  output logic [fsmc_pkg::OUT_DEPTH_W-1:0] out_return_depth,
  output logic                             out_fault
);
  import fsmc_pkg::*;

  localparam int CW   = CELL_BITS;
  localparam int DAW  = $clog2(DATA_DEPTH);
  localparam int RAW  = $clog2(RETURN_DEPTH);
  localparam int DCW  = $clog2(DATA_DEPTH + 1);
  localparam int RCW  = $clog2(RETURN_DEPTH + 1);
  localparam int MAXD = (DATA_DEPTH > RETURN_DEPTH) ? DATA_DEPTH : RETURN_DEPTH;
  localparam int CLW  = $clog2(MAXD);
  localparam int SHW  = $clog2(CELL_BITS);
  localparam int XW   = CELL_BITS + 12;
  localparam logic [CW-1:0] CW_C = CW'(CELL_BITS);

  logic [CW-1:0] dmem [DATA_DEPTH];
  logic [CW-1:0] rmem [RETURN_DEPTH];

  state_t state_r, state_nxt;
  op_t op_r;
  logic [31:0]    lit_r;
  logic [DCW-1:0] dcount_r, p_r;
  logic [RCW-1:0] rcount_r;
  logic [CLW-1:0] clr_r;
  logic [CW-1:0]  t_r [4];
  logic [CW-1:0]  wv_r [4];
  logic [CW-1:0]  rt_r, hold_r, drd_r, rrd_r;
  logic [2:0]     ri_r, nrd_r, wn_r, wj_r;
  logic [31:0]    top_r;
  logic [OUT_DEPTH_W-1:0] dd_r, rdo_r;
  logic           fault_r;

  logic           d_we, r_we;
  logic [DAW-1:0] d_raddr, d_waddr;
  logic [RAW-1:0] r_raddr, r_waddr;
  logic [CW-1:0]  d_wdata, r_wdata;

  logic           dec_bad, dec_under;
  logic [CW-1:0]  a, b, alu, lit_cell;
  logic           big;
  logic           c_over, c_fault, c_xgo;
  logic [DCW-1:0] c_nc;
  logic [RCW-1:0] c_nrc;
  logic [2:0]     c_wn;
  logic [CW-1:0]  c_wv [4];
  logic [DCW-1:0] dm1;
  logic           u_ok;
  logic [XW-1:0]  t0_x;

  assign dec_bad   = 32'(op_r) >= 32'(OP_COUNT);
  assign dec_under = (DCW'(op_dneed(op_r)) > dcount_r) || (RCW'(op_rneed(op_r)) > rcount_r);
  assign lit_cell  = CW'(lit_r);

  assign a   = t_r[1];
  assign b   = t_r[0];
  assign big = b >= CW_C;
  assign dm1 = dcount_r - DCW'(1);
  assign t0_x = XW'(t_r[0]);
  assign u_ok = t0_x < XW'(dm1);

  always_comb begin
    case (op_r)
      OP_ADD:    alu = a + b;
      OP_SUB:    alu = a - b;
      OP_MUL, OP_UMUL: alu = a * b;
      OP_MAX:    alu = ($signed(a) > $signed(b)) ? a : b;
      OP_MIN:    alu = ($signed(a) < $signed(b)) ? a : b;
      OP_LSHIFT: alu = big ? '0 : (a << b[SHW-1:0]);
      OP_RSHIFT: alu = big ? '0 : (a >> b[SHW-1:0]);
      OP_ASHIFT: alu = big ? {CW{a[CW-1]}} : CW'($signed(a) >>> b[SHW-1:0]);
      OP_AND:    alu = a & b;
      OP_OR:     alu = a | b;
      OP_XOR:    alu = a ^ b;
      OP_EQ:     alu = {CW{a == b}};
      OP_GT:     alu = {CW{$signed(a) > $signed(b)}};
      OP_LT:     alu = {CW{$signed(a) < $signed(b)}};
      OP_UGT:    alu = {CW{a > b}};
      default:   alu = {CW{a < b}};
    endcase
  end

  always_comb begin
    logic [1:0] dp;
    dp = op_dpush(op_r);
    if (op_r == OP_QDUP && t_r[0] == '0) begin
      dp = 2'd0;
    end
    c_over = ((dp != 2'd0) &&
              ((DCW + 2)'(dcount_r) + (DCW + 2)'(dp) > (DCW + 2)'(DATA_DEPTH))) ||
             (op_r == OP_TO_R && (RCW + 1)'(rcount_r) >= (RCW + 1)'(RETURN_DEPTH));
    c_fault = c_over;
    c_xgo   = 1'b0;
    c_nc    = dcount_r;
    c_nrc   = rcount_r;
    c_wn    = 3'd0;
    c_wv[0] = alu;
    c_wv[1] = t_r[0];
    c_wv[2] = t_r[0];
    c_wv[3] = t_r[1];
    if (!c_over) begin
      case (op_r)
        OP_LIT:  begin c_nc = dcount_r + DCW'(1); c_wn = 3'd1; c_wv[0] = lit_cell; end
        OP_DUP:  begin c_nc = dcount_r + DCW'(1); c_wn = 3'd1; c_wv[0] = t_r[0]; end
        OP_DUP2: begin
          c_nc = dcount_r + DCW'(2); c_wn = 3'd2; c_wv[0] = t_r[0]; c_wv[1] = t_r[1];
        end
        OP_QDUP: begin
          if (t_r[0] != '0) begin
            c_nc = dcount_r + DCW'(1); c_wn = 3'd1; c_wv[0] = t_r[0];
          end
        end
        OP_OVER: begin c_nc = dcount_r + DCW'(1); c_wn = 3'd1; c_wv[0] = t_r[1]; end
        OP_OVER2: begin
          c_nc = dcount_r + DCW'(2); c_wn = 3'd2; c_wv[0] = t_r[2]; c_wv[1] = t_r[3];
        end
        OP_PICK, OP_ROLL: begin
          if (u_ok) begin
            c_xgo = 1'b1;
          end else begin
            c_nc = dm1; c_fault = 1'b1;
          end
        end
        OP_DROP:  c_nc = dm1;
        OP_DROP2: c_nc = dcount_r - DCW'(2);
        OP_NIP:   begin c_nc = dm1; c_wn = 3'd1; c_wv[0] = t_r[0]; end
        OP_ROT: begin
          c_wn = 3'd3; c_wv[0] = t_r[2]; c_wv[1] = t_r[0]; c_wv[2] = t_r[1];
        end
        OP_MROT: begin
          c_wn = 3'd3; c_wv[0] = t_r[1]; c_wv[1] = t_r[2]; c_wv[2] = t_r[0];
        end
        OP_SWAP: begin c_wn = 3'd2; c_wv[0] = t_r[1]; c_wv[1] = t_r[0]; end
        OP_SWAP2: begin
          c_wn = 3'd4; c_wv[0] = t_r[2]; c_wv[1] = t_r[3]; c_wv[2] = t_r[0];
          c_wv[3] = t_r[1];
        end
        OP_TO_R: begin c_nc = dm1; c_nrc = rcount_r + RCW'(1); end
        OP_R_FROM: begin
          c_nc = dcount_r + DCW'(1); c_nrc = rcount_r - RCW'(1); c_wn = 3'd1;
          c_wv[0] = rt_r;
        end
        OP_R_FETCH, OP_I, OP_J: begin
          c_nc = dcount_r + DCW'(1); c_wn = 3'd1; c_wv[0] = rt_r;
        end
        OP_DEPTH: begin
          c_nc = dcount_r + DCW'(1); c_wn = 3'd1; c_wv[0] = CW'(dcount_r);
        end
        OP_RDEPTH: begin
          c_nc = dcount_r + DCW'(1); c_wn = 3'd1; c_wv[0] = CW'(rcount_r);
        end
        OP_DEPTH_SET: begin
          if (t0_x > XW'(DATA_DEPTH)) begin
            c_nc = DCW'(DATA_DEPTH); c_fault = 1'b1;
          end else begin
            c_nc = t_r[0][DCW-1:0];
          end
        end
        OP_RDEPTH_SET: begin
          c_nc = dm1;
          if (t0_x > XW'(RETURN_DEPTH)) begin
            c_nrc = RCW'(RETURN_DEPTH); c_fault = 1'b1;
          end else begin
            c_nrc = t_r[0][RCW-1:0];
          end
        end
        OP_ABS: begin
          c_wn = 3'd1; c_wv[0] = t_r[0][CW-1] ? ('0 - t_r[0]) : t_r[0];
        end
        OP_NEGATE: begin c_wn = 3'd1; c_wv[0] = '0 - t_r[0]; end
        OP_INVERT: begin c_wn = 3'd1; c_wv[0] = ~t_r[0]; end
        default:   begin c_nc = dm1; c_wn = 3'd1; c_wv[0] = alu; end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_r == CLW'(MAXD - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = (dec_bad || dec_under) ? S_FT : S_RD;
      S_RD: begin
        if (ri_r < nrd_r) begin
          state_nxt = S_RCAP;
        end else begin
          state_nxt = (op_rneed(op_r) != 2'd0) ? S_RRD : S_CALC;
        end
      end
      S_RCAP:   state_nxt = S_RD;
      S_RRD:    state_nxt = S_RRCAP;
      S_RRCAP:  state_nxt = S_CALC;
      S_CALC:   state_nxt = c_over ? S_FT : (c_xgo ? S_XRD : S_WR);
      S_XRD:    state_nxt = S_XCAP;
      S_XCAP:   state_nxt = (op_r == OP_ROLL) ? S_RL_RD : S_WR;
      S_RL_RD:  state_nxt = (p_r < dcount_r - DCW'(2)) ? S_RL_WR : S_WR;
      S_RL_WR:  state_nxt = S_RL_RD;
      S_WR:     if (wj_r >= wn_r) state_nxt = S_FT;
      S_FT:     state_nxt = S_FTCAP;
      S_FTCAP:  state_nxt = S_OUT;
      S_OUT:    if (!out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = state_r != S_IDLE;
    out_valid = state_r == S_OUT;
    d_we      = 1'b0;
    r_we      = 1'b0;
    d_waddr   = clr_r[DAW-1:0];
    d_wdata   = '0;
    r_waddr   = clr_r[RAW-1:0];
    r_wdata   = '0;
    d_raddr   = dm1[DAW-1:0];
    r_raddr   = RAW'(rcount_r - RCW'(1));
    case (state_r)
      S_CLEAR: begin
        d_we = (CLW + 1)'(clr_r) < (CLW + 1)'(DATA_DEPTH);
        r_we = (CLW + 1)'(clr_r) < (CLW + 1)'(RETURN_DEPTH);
      end
      S_RD:    d_raddr = DAW'(dm1 - DCW'(ri_r));
      S_RRD: begin
        if (op_r == OP_J) r_raddr = RAW'(rcount_r - RCW'(3));
      end
      S_CALC: begin
        r_we    = op_r == OP_TO_R && !c_over;
        r_waddr = rcount_r[RAW-1:0];
        r_wdata = t_r[0];
      end
      S_XRD:   d_raddr = DAW'(dcount_r - DCW'(2) - t_r[0][DCW-1:0]);
      S_RL_RD: d_raddr = DAW'(p_r + DCW'(1));
      S_RL_WR: begin
        d_we = 1'b1; d_waddr = p_r[DAW-1:0]; d_wdata = drd_r;
      end
      S_WR: begin
        d_we    = wj_r < wn_r;
        d_waddr = DAW'(dm1 - DCW'(wj_r));
        d_wdata = wv_r[wj_r[1:0]];
      end
      default: d_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    drd_r <= dmem[d_raddr];
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    rrd_r <= rmem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      dcount_r <= '0;
      rcount_r <= '0;
      fault_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: clr_r <= clr_r + CLW'(1);
        S_IDLE: begin
          op_r  <= op_t'(in_operation);
          lit_r <= in_literal;
        end
        S_DECODE: begin
          fault_r <= !dec_bad && dec_under;
          ri_r    <= 3'd0;
          nrd_r   <= op_dneed(op_r);
        end
        S_RCAP: begin
          t_r[ri_r[1:0]] <= drd_r;
          ri_r           <= ri_r + 3'd1;
        end
        S_RRCAP: rt_r <= rrd_r;
        S_CALC: begin
          fault_r  <= c_fault;
          dcount_r <= c_nc;
          rcount_r <= c_nrc;
          wn_r     <= c_wn;
          wj_r     <= 3'd0;
          wv_r     <= c_wv;
        end
        S_XCAP: begin
          hold_r   <= drd_r;
          wv_r[0]  <= drd_r;
          wn_r     <= 3'd1;
          p_r      <= dcount_r - DCW'(2) - t_r[0][DCW-1:0];
        end
        S_RL_RD: begin
          if (!(p_r < dcount_r - DCW'(2))) begin
            dcount_r <= dm1;
            wv_r[0]  <= hold_r;
          end
        end
        S_RL_WR: p_r <= p_r + DCW'(1);
        S_WR: wj_r <= wj_r + 3'd1;
        S_FTCAP: begin
          top_r <= (dcount_r == '0) ? '0 : OUT_CELL_W'(drd_r);
          dd_r  <= OUT_DEPTH_W'(dcount_r);
          rdo_r <= OUT_DEPTH_W'(rcount_r);
        end
        default: clr_r <= clr_r;
      endcase
    end
  end

  assign out_top_value    = top_r;
  assign out_data_depth   = dd_r;
  assign out_return_depth = rdo_r;
  assign out_fault        = fault_r;

endmodule

// ===== design/fsmc_checker.sv =====
module fsmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_top_value,
  input logic [6:0]  out_data_depth,
  input logic [6:0]  out_return_depth,
  input logic        out_fault
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_top_value) &&
    $stable(out_data_depth) && $stable(out_return_depth) && $stable(out_fault))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("request accepted while another is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while a result waits");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

endmodule

bind forth_stack_machine_core fsmc_checker u_fsmc_checker (.*);
